/* hdl/tmg_pkg.sv */
package tmg_pkg;

  // Clock and note queue sizing
  localparam int CLOCK_HZ    = 16000000;
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(2 * QUEUE_DEPTH);
  localparam int PTR_W1      = PTR_W + 1;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Front to back command queue
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Field widths
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 16;
  localparam int TOTAL_W = 20;
  localparam int HP_W    = 21;
  localparam int PSC_W   = 10;
  localparam int CMP_W   = 8;
  localparam int FD_W    = 29;  // 13-bit in-range frequency times 16-bit duration
  localparam int DIV_W   = FD_W + 1;
  localparam int CNTW    = $clog2(DIV_W + 1);

  // ms to half periods: divide by 1000 as a shift by 3, then a reciprocal
  // multiply for 125, exact for any product below 2^30
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 34;
  localparam int MSQ_W       = DIV_W - 3 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_125 = 28'd137438954;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_PLAY   = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_START  = 2'd3;

  // Prescaler select codes
  localparam logic [2:0] SEL_NONE = 3'd0;
  localparam logic [2:0] SEL_8    = 3'd1;
  localparam logic [2:0] SEL_32   = 3'd2;
  localparam logic [2:0] SEL_64   = 3'd3;
  localparam logic [2:0] SEL_128  = 3'd4;
  localparam logic [2:0] SEL_1024 = 3'd5;

  localparam logic [FREQ_W-1:0] FREQ_MIN     = 16'd33;
  localparam logic [FREQ_W-1:0] FREQ_MAX     = 16'd8000;
  localparam logic [FREQ_W-1:0] BAND_8_ABOVE  = 16'd4000;
  localparam logic [FREQ_W-1:0] BAND_32_ABOVE = 16'd3000;
  localparam logic [FREQ_W-1:0] BAND_64_ABOVE = 16'd2000;
  localparam logic [FREQ_W-1:0] BAND_128_ABOVE = 16'd500;
  localparam logic [FREQ_W-1:0] MS_PER_S     = 16'd1000;

  // Timer base per band: clock / (2 * N)
  localparam int K_8    = CLOCK_HZ / 2 / 8;
  localparam int K_32   = CLOCK_HZ / 2 / 32;
  localparam int K_64   = CLOCK_HZ / 2 / 64;
  localparam int K_128  = CLOCK_HZ / 2 / 128;
  localparam int K_1024 = CLOCK_HZ / 2 / 1024;

  // Pause notes time at 1 kHz on the /128 prescaler
  localparam int PAUSE_Q = CLOCK_HZ / 2 / 128 / 1000;
  localparam int PAUSE_CMP_I = (PAUSE_Q == 0) ? 0 : ((PAUSE_Q - 1 > 255) ? 255 : PAUSE_Q - 1);
  localparam logic [CMP_W-1:0] PAUSE_CMP = CMP_W'(PAUSE_CMP_I);

  typedef struct packed {
    logic [1:0]        op;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } cmd_item_t;

  typedef struct packed {
    logic               pin_level;
    logic               busy_res;
    logic               range_error;
    logic               queue_full;
    logic [TOTAL_W-1:0] melody_total_ms;
  } res_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    logic              in_range;
    logic [2:0]        band;
  } note_t;

  typedef struct packed {
    logic [1:0] kind;
    note_t      note;
  } qcmd_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [FREQ_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  function automatic logic freq_in_range(input logic [FREQ_W-1:0] f);
    return (f >= FREQ_MIN) && (f <= FREQ_MAX);
  endfunction

  function automatic logic [2:0] band_of(input logic [FREQ_W-1:0] f);
    if (f > BAND_8_ABOVE) return SEL_8;
    else if (f > BAND_32_ABOVE) return SEL_32;
    else if (f > BAND_64_ABOVE) return SEL_64;
    else if (f > BAND_128_ABOVE) return SEL_128;
    else return SEL_1024;
  endfunction

  function automatic logic [PSC_W:0] prescale_div(input logic [2:0] sel);
    logic [PSC_W:0] n;
    unique case (sel)
      SEL_8:    n = (PSC_W+1)'(8);
      SEL_32:   n = (PSC_W+1)'(32);
      SEL_64:   n = (PSC_W+1)'(64);
      SEL_128:  n = (PSC_W+1)'(128);
      SEL_1024: n = (PSC_W+1)'(1024);
      default:  n = (PSC_W+1)'(1);
    endcase
    return n;
  endfunction

  function automatic logic [DIV_W-1:0] k_of(input logic [2:0] sel);
    logic [DIV_W-1:0] k;
    unique case (sel)
      SEL_8:    k = DIV_W'(K_8);
      SEL_32:   k = DIV_W'(K_32);
      SEL_64:   k = DIV_W'(K_64);
      SEL_128:  k = DIV_W'(K_128);
      SEL_1024: k = DIV_W'(K_1024);
      default:  k = '0;
    endcase
    return k;
  endfunction

  // Quotient minus one, clamped to the compare register
  function automatic logic [CMP_W-1:0] cmp_sat(input logic [DIV_W-1:0] q);
    logic [DIV_W-1:0] qm1;
    qm1 = q - DIV_W'(1);
    if (q == '0) return '0;
    else if (qm1 > DIV_W'(255)) return CMP_W'(255);
    else return qm1[CMP_W-1:0];
  endfunction

  // Half-period count from 2 * freq * dur
  function automatic logic [HP_W-1:0] halves_of(input logic [DIV_W-1:0] p);
    logic [MSQ_W-1:0] m;
    m = MSQ_W'(p[DIV_W-1:3]) * MSQ_W'(RECIP_125);
    return m[RECIP_SHIFT +: HP_W];
  endfunction

  // Queue pointers run modulo twice the depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(2 * QUEUE_DEPTH - 1)) return '0;
    else return p + PTR_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
    if (p >= PTR_W'(QUEUE_DEPTH)) return IDX_W'(p - PTR_W'(QUEUE_DEPTH));
    else return IDX_W'(p);
  endfunction

  function automatic logic [PTR_W-1:0] queue_count(input logic [PTR_W-1:0] head,
                                                   input logic [PTR_W-1:0] tail);
    logic [PTR_W1-1:0] diff;
    if (tail >= head) diff = {1'b0, tail} - {1'b0, head};
    else diff = {1'b0, tail} + PTR_W1'(2 * QUEUE_DEPTH) - {1'b0, head};
    return PTR_W'(diff);
  endfunction

endpackage

/* hdl/tmg_front.sv */
module tmg_front (
  input  tmg_pkg::cmd_item_t cmd,
  output tmg_pkg::qcmd_t     qc
);
  import tmg_pkg::*;

  // Band and range do not depend on the pause code, so they are settled here
  always_comb begin
    qc.kind          = cmd.op;
    qc.note.freq     = cmd.freq;
    qc.note.dur      = cmd.dur;
    qc.note.in_range = freq_in_range(cmd.freq);
    qc.note.band     = band_of(cmd.freq);
  end

endmodule

/* hdl/tmg_cmd_fifo.sv */
module tmg_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tmg_pkg::qcmd_t din,
  output logic           full,
  input  logic           pop,
  output tmg_pkg::qcmd_t dout,
  output logic           empty
);
  import tmg_pkg::*;

  qcmd_t                 slots [CMDQ_DEPTH];
  logic [CMDQ_IDX_W-1:0] wr_ptr;
  logic [CMDQ_IDX_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] fill;
  logic                  do_push;
  logic                  do_pop;

  function automatic logic [CMDQ_IDX_W-1:0] inc(input logic [CMDQ_IDX_W-1:0] p);
    if (p == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) return '0;
    else return p + CMDQ_IDX_W'(1);
  endfunction

  assign full    = (fill == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/tmg_divider.sv */
module tmg_divider (
  input  logic              clk,
  input  logic              rst,
  input  tmg_pkg::div_req_t req,
  output tmg_pkg::div_rsp_t rsp
);
  import tmg_pkg::*;

  // Restoring divider, one quotient bit per cycle
  logic                busy;
  logic                done;
  logic [CNTW-1:0]     steps;
  logic [DIV_W-1:0]    num_sh;
  logic [DIV_W-1:0]    quot;
  logic [FREQ_W-1:0]   den;
  logic [FREQ_W-1:0]   rem;
  logic [FREQ_W:0]     trial;
  logic                qbit;

  always_comb begin
    trial = {rem, num_sh[DIV_W-1]};
    qbit  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= CNTW'(DIV_W);
    end else if (busy) begin
      steps <= steps - CNTW'(1);
      if (steps == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      den    <= req.den;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[DIV_W-2:0], 1'b0};
      quot   <= {quot[DIV_W-2:0], qbit};
      if (qbit) begin
        rem <= FREQ_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[FREQ_W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* hdl/tmg_back.sv */
module tmg_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        pause_code,
  input  logic               qc_valid,
  input  tmg_pkg::qcmd_t     qc,
  output logic               qc_pop,
  output tmg_pkg::div_req_t  div_req,
  input  tmg_pkg::div_rsp_t  div_rsp,
  output logic               res_valid,
  input  logic               res_ready,
  output tmg_pkg::res_item_t res
);
  import tmg_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_ADV_CHECK = 3'd1;
  localparam logic [2:0] ST_ADV_READ  = 3'd2;
  localparam logic [2:0] ST_ARM       = 3'd3;
  localparam logic [2:0] ST_DIV_CMP   = 3'd4;
  localparam logic [2:0] ST_ARM_FIN   = 3'd6;

  logic [2:0]         state, state_next;
  logic [PSC_W-1:0]   prescale_counter, prescale_counter_next;
  logic [2:0]         prescale_select, prescale_select_next;
  logic [CMP_W-1:0]   compare_counter, compare_counter_next;
  logic [CMP_W-1:0]   compare_value, compare_value_next;
  logic [HP_W-1:0]    half_periods_left, half_periods_left_next;
  logic               silent_flag, silent_flag_next;
  logic               running_flag, running_flag_next;
  logic               output_level, output_level_next;
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   tail, tail_next;
  logic [TOTAL_W-1:0] queued_total, queued_total_next;
  logic [TOTAL_W-1:0] pend_total, pend_total_next;
  note_t              note, note_next;
  logic [DIV_W-1:0]   prod, prod_next;
  logic [HP_W-1:0]    cnt, cnt_next;
  logic [2:0]         arm_sel, arm_sel_next;
  logic               arm_silent, arm_silent_next;

  note_t              mem [QUEUE_DEPTH];
  note_t              mem_rd;
  logic               mem_we;

  logic               out_free;
  logic               emit;
  logic               err;
  logic               full;
  res_item_t          res_next;
  logic [PTR_W-1:0]   count;
  logic [PSC_W:0]     pc_inc;
  logic [HP_W-1:0]    hp_dec;
  logic [TOTAL_W:0]   total_sum;
  logic [FD_W-1:0]    fd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_idx(tail)] <= qc.note;
    end
    mem_rd <= mem[ptr_idx(head)];
  end

  always_comb begin
    state_next             = state;
    prescale_counter_next  = prescale_counter;
    prescale_select_next   = prescale_select;
    compare_counter_next   = compare_counter;
    compare_value_next     = compare_value;
    half_periods_left_next = half_periods_left;
    silent_flag_next       = silent_flag;
    running_flag_next      = running_flag;
    output_level_next      = output_level;
    head_next              = head;
    tail_next              = tail;
    queued_total_next      = queued_total;
    pend_total_next        = pend_total;
    note_next              = note;
    prod_next              = prod;
    cnt_next               = cnt;
    arm_sel_next           = arm_sel;
    arm_silent_next        = arm_silent;
    qc_pop                 = 1'b0;
    mem_we                 = 1'b0;
    emit                   = 1'b0;
    err                    = 1'b0;
    full                   = 1'b0;
    div_req                = '0;

    out_free  = !res_valid || res_ready;
    count     = queue_count(head, tail);
    pc_inc    = {1'b0, prescale_counter} + (PSC_W+1)'(1);
    hp_dec    = half_periods_left - HP_W'(1);
    total_sum = {1'b0, queued_total} + (TOTAL_W+1)'(qc.note.dur);
    fd        = FD_W'(note.freq[12:0]) * FD_W'(note.dur);

    unique case (state)
      ST_IDLE: begin
        // a beat is taken only while the result slot is free or draining
        if (qc_valid && out_free) begin
          qc_pop          = 1'b1;
          pend_total_next = '0;
          unique case (qc.kind)
            OP_TICK: begin
              emit = 1'b1;
              if (running_flag) begin
                if (pc_inc >= prescale_div(prescale_select)) begin
                  prescale_counter_next = '0;
                  if (compare_counter == compare_value) begin
                    compare_counter_next   = '0;
                    half_periods_left_next = hp_dec;
                    if (hp_dec != '0) begin
                      if (!silent_flag) begin
                        output_level_next = !output_level;
                      end
                    end else begin
                      emit       = 1'b0;
                      state_next = ST_ADV_CHECK;
                    end
                  end else begin
                    compare_counter_next = compare_counter + CMP_W'(1);
                  end
                end else begin
                  prescale_counter_next = pc_inc[PSC_W-1:0];
                end
              end
            end
            OP_PLAY: begin
              head_next         = tail;
              queued_total_next = '0;
              note_next         = qc.note;
              state_next        = ST_ARM;
            end
            OP_APPEND: begin
              emit = 1'b1;
              if (count == PTR_W'(QUEUE_DEPTH)) begin
                full = 1'b1;
              end else begin
                mem_we    = 1'b1;
                tail_next = ptr_inc(tail);
                if (total_sum > {1'b0, TOTAL_MAX}) begin
                  queued_total_next = TOTAL_MAX;
                end else begin
                  queued_total_next = total_sum[TOTAL_W-1:0];
                end
              end
            end
            OP_START: begin
              pend_total_next   = queued_total;
              queued_total_next = '0;
              state_next        = ST_ADV_CHECK;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_ADV_CHECK: begin
        if (count == '0) begin
          running_flag_next      = 1'b0;
          prescale_select_next   = SEL_NONE;
          prescale_counter_next  = '0;
          compare_counter_next   = '0;
          compare_value_next     = '0;
          half_periods_left_next = '0;
          output_level_next      = 1'b0;
          emit                   = 1'b1;
          state_next             = ST_IDLE;
        end else begin
          head_next  = ptr_inc(head);
          state_next = ST_ADV_READ;
        end
      end

      ST_ADV_READ: begin
        note_next  = mem_rd;
        state_next = ST_ARM;
      end

      ST_ARM: begin
        running_flag_next      = 1'b0;
        prescale_select_next   = SEL_NONE;
        prescale_counter_next  = '0;
        compare_counter_next   = '0;
        compare_value_next     = '0;
        half_periods_left_next = '0;
        if (note.freq == pause_code) begin
          compare_value_next = PAUSE_CMP;
          cnt_next           = {{(HP_W-DUR_W-1){1'b0}}, note.dur, 1'b0};
          arm_sel_next       = SEL_128;
          arm_silent_next    = 1'b1;
          state_next         = ST_ARM_FIN;
        end else if (!note.in_range) begin
          // out of band: stop and drop whatever is queued
          head_next  = tail;
          err        = 1'b1;
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          prod_next       = {fd, 1'b0};
          div_req.start   = 1'b1;
          div_req.num     = k_of(note.band);
          div_req.den     = note.freq;
          arm_sel_next    = note.band;
          arm_silent_next = 1'b0;
          state_next      = ST_DIV_CMP;
        end
      end

      ST_DIV_CMP: begin
        if (div_rsp.done) begin
          compare_value_next = cmp_sat(div_rsp.quot);
          cnt_next           = halves_of(prod);
          state_next         = ST_ARM_FIN;
        end
      end

      ST_ARM_FIN: begin
        // zero-length note ends at once and the next one is tried
        if (cnt == '0) begin
          state_next = ST_ADV_CHECK;
        end else begin
          half_periods_left_next = cnt;
          prescale_select_next   = arm_sel;
          running_flag_next      = 1'b1;
          silent_flag_next       = arm_silent;
          emit                   = 1'b1;
          state_next             = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res_next.pin_level       = output_level_next;
    res_next.busy_res        = running_flag_next;
    res_next.range_error     = err;
    res_next.queue_full      = full;
    res_next.melody_total_ms = pend_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      prescale_counter  <= '0;
      prescale_select   <= SEL_NONE;
      compare_counter   <= '0;
      compare_value     <= '0;
      half_periods_left <= '0;
      silent_flag       <= 1'b0;
      running_flag      <= 1'b0;
      output_level      <= 1'b0;
      head              <= '0;
      tail              <= '0;
      queued_total      <= '0;
      res_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      prescale_counter  <= prescale_counter_next;
      prescale_select   <= prescale_select_next;
      compare_counter   <= compare_counter_next;
      compare_value     <= compare_value_next;
      half_periods_left <= half_periods_left_next;
      silent_flag       <= silent_flag_next;
      running_flag      <= running_flag_next;
      output_level      <= output_level_next;
      head              <= head_next;
      tail              <= tail_next;
      queued_total      <= queued_total_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_total <= pend_total_next;
    note       <= note_next;
    prod       <= prod_next;
    cnt        <= cnt_next;
    arm_sel    <= arm_sel_next;
    arm_silent <= arm_silent_next;
    if (emit) begin
      res <= res_next;
    end
  end

endmodule

/* hdl/tone_melody_generator.sv */
// Square-wave tone generator with a note queue.
// cmd channel (valid/ready): op 0 is one clock tick, op 1 plays a single note,
// op 2 appends a note to the melody queue, op 3 starts the melody.
// res channel (valid/ready): exactly one result beat per cmd beat, in order,
// carrying the pin level, busy, range error, queue full and, on start, the
// total queued duration in ms.
// APB port: register 0 at address 0 holds the pause code (16 bits).
// Ticks and appends run at one beat per cycle while res_ready stays high
// and no note is being armed. Arming a note (play, start, or a tick that
// ends a note and moves on to the next queued one) runs the bit-serial
// divider that works out the compare value; the half-period count comes
// from a reciprocal multiply meanwhile. Every zero-length note skipped in
// the queue adds another such pass; a pause note is armed without the divider.
// A two-beat command queue sits between the decoder and the sequencer, and
// the result register holds one beat: when res_ready is low the sequencer
// waits and the command queue fills, then cmd_ready drops.
// Synchronous reset stops the generator, drives the pin low, empties the
// melody queue and clears the pause code; no clearing pass is needed.
module tone_melody_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  tmg_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output tmg_pkg::res_item_t res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tmg_pkg::*;

  localparam logic REG_PAUSE_CODE = 1'b0;

  logic [15:0] pause_code;
  qcmd_t       fq_in;
  qcmd_t       fq_out;
  logic        fq_full;
  logic        fq_empty;
  logic        fq_pop;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pause_code <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PAUSE_CODE)) begin
      pause_code <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_PAUSE_CODE) begin
      prdata = {16'b0, pause_code};
    end else begin
      prdata = '0;
    end
  end

  assign cmd_ready = !fq_full;

  tmg_front u_front (
    .cmd (cmd),
    .qc  (fq_in)
  );

  tmg_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_valid && cmd_ready),
    .din   (fq_in),
    .full  (fq_full),
    .pop   (fq_pop),
    .dout  (fq_out),
    .empty (fq_empty)
  );

  tmg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tmg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pause_code (pause_code),
    .qc_valid   (!fq_empty),
    .qc         (fq_out),
    .qc_pop     (fq_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

/* hdl/tmg_checker.sv */
module tmg_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input tmg_pkg::cmd_item_t cmd,
  input logic               res_valid,
  input logic               res_ready,
  input tmg_pkg::res_item_t res,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);
  import tmg_pkg::*;

  // no result beat straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat pending after reset");

  // a beat held back by the receiver keeps its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("stalled result beat changed");

  // a range error always leaves the generator stopped
  a_err_stops: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.range_error) |-> !res.busy_res)
    else $error("range error with generator still busy");

  // only an append reports a full queue, only a note reports a range error
  a_err_full_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.range_error && res.queue_full))
    else $error("range error and queue full in one beat");

  // the pause code reads back as written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) |=>
      ((paddr[2] != 1'b0) || (prdata == {16'b0, $past(pwdata[15:0])})))
    else $error("pause code read-back mismatch");

endmodule

bind tone_melody_generator tmg_checker u_chk (.*);

/* tb/tone_melody_generator_test.sv */
`timescale 1ns / 100ps

module tone_melody_generator_test;
  import tmg_pkg::*;

  localparam int LIMIT = 5000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] PAUSE_ADDR = 3'd0;

  localparam res_item_t BEAT_IDLE = '0;
  localparam res_item_t BEAT_RANGE = '{pin_level: 1'b0, busy_res: 1'b0, range_error: 1'b1,
                                       queue_full: 1'b0, melody_total_ms: '0};

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] freq;
    logic [15:0] dur;
    logic [4:0]  reps;
    logic        pinned;
    res_item_t   want;
  } plan_row_t;

  localparam int PLAN_LEN = 15;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{OP_TICK,   16'd0,     16'd0,     5'd1,  1'b1, BEAT_IDLE},  // stopped: tick does nothing
    '{OP_PLAY,   16'd32,    16'd100,   5'd1,  1'b1, BEAT_RANGE},
    '{OP_PLAY,   16'd8001,  16'd100,   5'd1,  1'b1, BEAT_RANGE},
    '{OP_PLAY,   16'd33,    16'd0,     5'd1,  1'b1, BEAT_IDLE},  // zero count ends at once
    '{OP_PLAY,   16'd4001,  16'd1,     5'd1,  1'b0, BEAT_IDLE},
    '{OP_TICK,   16'd0,     16'd0,     5'd2,  1'b0, BEAT_IDLE},
    '{OP_APPEND, 16'd8000,  16'hFFFF,  5'd17, 1'b0, BEAT_IDLE},  // last one dropped, queue full
    '{OP_START,  16'd0,     16'd0,     5'd1,  1'b0, BEAT_IDLE},
    '{OP_PLAY,   16'd0,     16'd1,     5'd1,  1'b0, BEAT_IDLE},  // pause note, code 0
    '{OP_START,  16'd0,     16'd0,     5'd1,  1'b1, BEAT_IDLE},  // empty queue
    '{OP_APPEND, 16'd3000,  16'd0,     5'd1,  1'b0, BEAT_IDLE},
    '{OP_APPEND, 16'd100,   16'd7,     5'd1,  1'b0, BEAT_IDLE},
    '{OP_APPEND, 16'hFFFF,  16'd3,     5'd1,  1'b0, BEAT_IDLE},
    '{OP_START,  16'd0,     16'd0,     5'd1,  1'b0, BEAT_IDLE},  // skips the empty note
    '{OP_START,  16'd0,     16'd0,     5'd1,  1'b1, BEAT_RANGE}  // queued note out of band
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  cmd_item_t          cmd = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  res_item_t          res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int        errors = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  res_item_t tone_res_q [$];

  // generator state as the block should hold it
  logic [15:0] pause_q = '0;
  logic [9:0]  psc_q = '0;
  logic [2:0]  sel_q = SEL_NONE;
  logic [7:0]  cmp_cnt_q = '0;
  logic [7:0]  cmp_val_q = '0;
  logic [20:0] halves_q = '0;
  logic        silent_q = 1'b0;
  logic        running_q = 1'b0;
  logic        pin_q = 1'b0;
  logic [31:0] notes_q [QUEUE_DEPTH];
  int          head_q = 0;
  int          tail_q = 0;
  logic [20:0] total_q = '0;

  typedef enum {ARM_OK, ARM_RANGE, ARM_EMPTY} arm_t;

  tone_melody_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned div_of(input logic [2:0] s);
    case (s)
      SEL_8:    return 8;
      SEL_32:   return 32;
      SEL_64:   return 64;
      SEL_128:  return 128;
      SEL_1024: return 1024;
      default:  return 1;
    endcase
  endfunction

  function automatic logic [7:0] cmp_for(input longint unsigned n, input longint unsigned f);
    longint unsigned q;
    q = 64'(CLOCK_HZ) / 2 / n / f;
    if (q == 0) return 8'd0;
    q = q - 1;
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  function automatic int notes_held();
    return (tail_q + 2 * QUEUE_DEPTH - head_q) % (2 * QUEUE_DEPTH);
  endfunction

  function automatic void gen_stop();
    running_q = 1'b0;
    sel_q = SEL_NONE;
    psc_q = '0;
    cmp_cnt_q = '0;
    cmp_val_q = '0;
    halves_q = '0;
  endfunction

  function automatic arm_t arm_note(input logic [15:0] f, input logic [15:0] d);
    logic [2:0] s;
    longint unsigned c;
    gen_stop();
    if (f == pause_q) begin
      s = SEL_128;
      cmp_val_q = cmp_for(128, MS_PER_S);
      c = 2 * 64'(d);
      silent_q = 1'b1;
    end else if (f < FREQ_MIN || f > FREQ_MAX) begin
      return ARM_RANGE;
    end else begin
      if (f > BAND_8_ABOVE) s = SEL_8;
      else if (f > BAND_32_ABOVE) s = SEL_32;
      else if (f > BAND_64_ABOVE) s = SEL_64;
      else if (f > BAND_128_ABOVE) s = SEL_128;
      else s = SEL_1024;
      cmp_val_q = cmp_for(div_of(s), f);
      c = (2 * 64'(f) * 64'(d)) / MS_PER_S;
      silent_q = 1'b0;
    end
    if (c == 0) begin
      cmp_val_q = '0;
      return ARM_EMPTY;
    end
    halves_q = 21'(c);
    sel_q = s;
    running_q = 1'b1;
    return ARM_OK;
  endfunction

  // arm queued notes until one plays; 1 on a band error
  function automatic logic queue_next();
    logic [31:0] e;
    arm_t r;
    while (notes_held() != 0) begin
      e = notes_q[head_q % QUEUE_DEPTH];
      head_q = (head_q + 1) % (2 * QUEUE_DEPTH);
      r = arm_note(e[31:16], e[15:0]);
      if (r == ARM_OK) return 1'b0;
      if (r == ARM_RANGE) begin
        gen_stop();
        head_q = tail_q;
        return 1'b1;
      end
    end
    gen_stop();
    pin_q = 1'b0;
    return 1'b0;
  endfunction

  function automatic res_item_t tone_step(input cmd_item_t c);
    res_item_t r;
    logic [10:0] nxt;
    arm_t a;
    r = '0;
    case (c.op)
      OP_TICK: begin
        if (running_q) begin
          nxt = {1'b0, psc_q} + 11'd1;
          if (nxt >= div_of(sel_q)) begin
            psc_q = '0;
            if (cmp_cnt_q == cmp_val_q) begin
              cmp_cnt_q = '0;
              halves_q = halves_q - 21'd1;
              if (halves_q != 0) begin
                if (!silent_q) pin_q = ~pin_q;
              end else begin
                r.range_error = queue_next();
              end
            end else begin
              cmp_cnt_q = cmp_cnt_q + 8'd1;
            end
          end else begin
            psc_q = nxt[9:0];
          end
        end
      end
      OP_PLAY: begin
        head_q = tail_q;
        total_q = '0;
        a = arm_note(c.freq, c.dur);
        if (a == ARM_RANGE) begin
          gen_stop();
          r.range_error = 1'b1;
        end else if (a == ARM_EMPTY) begin
          gen_stop();
          pin_q = 1'b0;
        end
      end
      OP_APPEND: begin
        if (notes_held() >= QUEUE_DEPTH) begin
          r.queue_full = 1'b1;
        end else begin
          notes_q[tail_q % QUEUE_DEPTH] = {c.freq, c.dur};
          tail_q = (tail_q + 1) % (2 * QUEUE_DEPTH);
          total_q = total_q + c.dur;
          if (total_q > 21'hFFFFF) total_q = 21'hFFFFF;
        end
      end
      default: begin
        r.melody_total_ms = total_q[19:0];
        total_q = '0;
        r.range_error = queue_next();
      end
    endcase
    r.pin_level = pin_q;
    r.busy_res = running_q;
    return r;
  endfunction

  function automatic void cmp_field(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 100) $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic void check_beat(input res_item_t got);
    res_item_t want;
    if (tone_res_q.size() == 0) begin
      errors++;
      if (errors <= 100) $display("%0t ns: result beat with nothing pending, got %h", $time, got);
      return;
    end
    want = tone_res_q.pop_front();
    cmp_field("pin_level", 32'(want.pin_level), 32'(got.pin_level));
    cmp_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
    cmp_field("range_error", 32'(want.range_error), 32'(got.range_error));
    cmp_field("queue_full", 32'(want.queue_full), 32'(got.queue_full));
    cmp_field("melody_total_ms", 32'(want.melody_total_ms), 32'(got.melody_total_ms));
  endfunction

  task automatic offer(input logic [1:0] op, input logic [15:0] f, input logic [15:0] d,
                       input logic pinned = 1'b0, input res_item_t want = '0);
    cmd_item_t c;
    res_item_t guess;
    c.op = op;
    c.freq = f;
    c.dur = d;
    guess = tone_step(c);
    tone_res_q.push_back(pinned ? want : guess);
    while (!calm && $urandom_range(0, 99) < 10) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // sender waits for every outstanding result beat
  task automatic park();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (tone_res_q.size() != 0);
  endtask

  task automatic apb_write(input logic [2:0] a, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] a, output logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    v = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_note(output logic [15:0] f, output logic [15:0] d);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        f = 16'($urandom_range(4001, 8000));
        d = 16'd1;
      end
      3: begin
        f = pause_q;
        d = 16'($urandom_range(0, 1));
      end
      4: begin
        f = 16'($urandom_range(33, 8000));
        d = 16'd0;
      end
      5: begin
        f = 16'($urandom_range(33, 499));
        d = 16'd1;
      end
      6: begin
        if ($urandom_range(0, 1) == 1) f = 16'($urandom_range(0, 32));
        else f = 16'($urandom_range(8001, 65535));
        d = 16'($urandom);
      end
      7, 8: begin
        f = 16'($urandom_range(33, 8000));
        d = 16'($urandom_range(1, 3));
      end
      default: begin
        f = 16'($urandom);
        d = 16'($urandom);
      end
    endcase
  endtask

  // a short burst of ticks, every one counted against the budget
  task automatic run_ticks(output int weight);
    int n;
    n = $urandom_range(0, 30);
    repeat (n) offer(OP_TICK, 16'($urandom), 16'($urandom));
    weight = n;
  endtask

  task automatic run_phase(input int budget);
    int done_n;
    int k;
    int w;
    int pick;
    logic [15:0] f;
    logic [15:0] d;
    done_n = 0;
    while (done_n < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
        repeat (k) begin
          rand_note(f, d);
          offer(OP_APPEND, f, d);
        end
        offer(OP_START, 16'($urandom), 16'($urandom));
        run_ticks(w);
        done_n += k + 1 + w;
      end else if (pick < 75) begin
        rand_note(f, d);
        offer(OP_PLAY, f, d);
        run_ticks(w);
        done_n += 1 + w;
      end else if (pick < 95) begin
        repeat (6) offer(2'($urandom), 16'($urandom), 16'($urandom));
        done_n += 6;
      end else begin
        park();
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ready <= 1'b0;
      end else begin
        if (res_valid && res_ready) check_beat(res);
        if (hold_left > 0) begin
          hold_left--;
          res_ready <= 1'b0;
        end else if (hold_req) begin
          hold_req = 1'b0;
          hold_left = HOLD_CYCLES;
          res_ready <= 1'b0;
        end else begin
          res_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
      end
    end
  end

  initial begin
    for (int cyc = 0; cyc < LIMIT; cyc++) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [15:0] codes [5];
    logic [31:0] rd;
    int row;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read(PAUSE_ADDR, rd);
    cmp_field("pause_code after reset", 32'd0, rd);

    for (row = 0; row < PLAN_LEN; row++) begin
      repeat (PLAN[row].reps)
        offer(PLAN[row].op, PLAN[row].freq, PLAN[row].dur, PLAN[row].pinned, PLAN[row].want);
    end

    codes = '{16'hFFFF, 16'd1000, 16'd20, 16'd0, 16'($urandom)};
    for (int p = 0; p < 5; p++) begin
      park();
      apb_write(PAUSE_ADDR, {16'd0, codes[p]});
      apb_read(PAUSE_ADDR, rd);
      cmp_field("pause_code readback", {16'd0, codes[p]}, rd);
      pause_q = codes[p];
      calm = (p == 2);
      if (p == 1) hold_req = 1'b1;
      run_phase(200);
    end

    park();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
